### design/dpds_pkg.sv
// Shared types and constants of the depth pooling and disparity scale block.
package dpds_pkg;

	// Width that holds any clamped frame dimension up to 8192.
	localparam int unsigned DIM_W = 14;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CELL_W = 22;
	localparam int unsigned OUT_TDATA_W = 88;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NORMALIZE_ENABLE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_GAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_GAIN = 3'd4;

	// Normalized depth saturates at 100.0 in Q12.20.
	localparam logic [47:0] DEPTH_CLAMP = 48'd104857600;
	// Upper word of 2^44, the Q8.24 reciprocal numerator.
	localparam logic [31:0] DISP_NUM_HI = 32'h0000_1000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MULT,
		ST_POOL,
		ST_DIV_DISP,
		ST_WAIT_DISP,
		ST_DIV_SCALE,
		ST_WAIT_SCALE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic mult;
		logic pool;
		logic div_start;
		logic div_sel_scale;
		logic cap_disp;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic closes_cell;
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage

### design/dpds_div.sv
// Bit-serial restoring divider giving a saturated 32-bit quotient of a 64-bit numerator.
module dpds_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num_hi,
	input  logic [31:0] num_lo,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [32:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[31]};
	assign fits = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				// A quotient of 2^32 or more, or a zero divisor, saturates at once.
				if (num_hi >= divisor) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q <= 5'd31;
				end
			end else if (busy_q) begin
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num_hi;
			dvs_q <= divisor;
			quo_q <= (num_hi >= divisor) ? 32'hFFFF_FFFF : num_lo;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

### design/dpds_dp.sv
// Datapath: configuration registers, raster counters, pooling, line store, divider, output register.
module dpds_dp #(
	parameter int unsigned MAX_WIDTH = 4096,
	parameter int unsigned MAX_HEIGHT = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dpds_pkg::dp_cmd_t                   cmd,
	output dpds_pkg::dp_status_t                status,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dpds_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [31:0]                         cfg_data,
	input  logic [31:0]                         sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [dpds_pkg::OUT_TDATA_W-1:0]    out_data,
	output logic                                out_last
);
	import dpds_pkg::*;

	localparam int unsigned COL_W = $clog2(MAX_WIDTH);
	localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);
	localparam int unsigned STORE_DEPTH = MAX_WIDTH / 2;
	localparam int unsigned SLOT_W = $clog2(STORE_DEPTH);

	logic [12:0] frame_width_q;
	logic [12:0] frame_height_q;
	logic        normalize_q;
	logic [31:0] depth_gain_q;
	logic [31:0] scale_gain_q;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [CELL_W-1:0] cell_cnt_q;

	logic [31:0]       sample_q;
	logic [63:0]       product_q;
	logic [31:0]       pair_q;
	logic [31:0]       store_rd_q;
	logic [31:0]       min_q;
	logic [31:0]       disp_q;
	logic              active_q;
	logic              odd_col_q;
	logic              odd_row_q;
	logic              last_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CELL_W-1:0] index_q;

	logic              out_valid_q;
	logic [31:0]       out_disp_q;
	logic [31:0]       out_scale_q;
	logic [CELL_W-1:0] out_index_q;
	logic              out_last_q;

	logic [31:0] row_store [STORE_DEPTH];

	logic [DIM_W-1:0] fw_ext, fh_ext, w, h, w_even, h_even, col_ext, row_ext;
	logic             col_wrap, row_wrap, active, is_cell;
	logic [SLOT_W-1:0] slot;
	logic [47:0]      scaled;
	logic [31:0]      depth, pair_min, cell_min;
	logic [31:0]      div_hi, div_lo, div_dvs, div_quo;
	logic             div_done;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= 13'd640;
			frame_height_q <= 13'd480;
			normalize_q <= 1'b0;
			depth_gain_q <= 32'd65536;
			scale_gain_q <= 32'd16777216;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH: frame_width_q <= cfg_data[12:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[12:0];
				REG_NORMALIZE_ENABLE: normalize_q <= cfg_data[0];
				REG_DEPTH_GAIN: depth_gain_q <= cfg_data;
				REG_SCALE_GAIN: scale_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the frame size into the supported range.
	always_comb begin
		fw_ext = DIM_W'(frame_width_q);
		fh_ext = DIM_W'(frame_height_q);
		if (fw_ext < DIM_W'(2)) w = DIM_W'(2);
		else if (fw_ext > DIM_W'(MAX_WIDTH)) w = DIM_W'(MAX_WIDTH);
		else w = fw_ext;
		if (fh_ext < DIM_W'(2)) h = DIM_W'(2);
		else if (fh_ext > DIM_W'(MAX_HEIGHT)) h = DIM_W'(MAX_HEIGHT);
		else h = fh_ext;
		w_even = {w[DIM_W-1:1], 1'b0};
		h_even = {h[DIM_W-1:1], 1'b0};
		col_ext = DIM_W'(col_q);
		row_ext = DIM_W'(row_q);
		col_wrap = (col_ext + DIM_W'(1)) >= w;
		row_wrap = (row_ext + DIM_W'(1)) >= h;
		active = (col_ext < w_even) && (row_ext < h_even);
		is_cell = active && col_q[0] && row_q[0];
		slot = col_q[SLOT_W:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			cell_cnt_q <= '0;
		end else if (cmd.accept) begin
			if (col_wrap) begin
				col_q <= '0;
				if (row_wrap) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
			if (col_wrap && row_wrap) begin
				cell_cnt_q <= '0;
			end else if (is_cell) begin
				cell_cnt_q <= cell_cnt_q + CELL_W'(1);
			end
		end
	end

	// Capture the item and what its position means for pooling.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			odd_col_q <= 1'b0;
			odd_row_q <= 1'b0;
			pair_q <= '0;
		end else begin
			if (cmd.accept) begin
				active_q <= active;
				odd_col_q <= col_q[0];
				odd_row_q <= row_q[0];
			end
			if (cmd.pool && active_q && !odd_col_q) begin
				pair_q <= depth;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= sample;
			slot_q <= slot;
			index_q <= cell_cnt_q;
			last_q <= (col_ext == w_even - DIM_W'(1)) && (row_ext == h_even - DIM_W'(1));
			store_rd_q <= row_store[slot];
		end
		if (cmd.mult) begin
			product_q <= 64'(sample_q) * 64'(depth_gain_q);
		end
		if (cmd.pool && active_q && odd_col_q && !odd_row_q) begin
			row_store[slot_q] <= pair_min;
		end
		if (cmd.pool) begin
			min_q <= cell_min;
		end
		if (cmd.cap_disp) begin
			disp_q <= div_quo;
		end
	end

	always_comb begin
		scaled = product_q[63:16];
		if (!normalize_q) depth = sample_q;
		else if (scaled > DEPTH_CLAMP) depth = DEPTH_CLAMP[31:0];
		else depth = scaled[31:0];
		pair_min = (pair_q < depth) ? pair_q : depth;
		cell_min = (pair_min < store_rd_q) ? pair_min : store_rd_q;
	end

	// Disparity is 2^44 / min; scale is (scale_gain << 20) / disparity. Disparity never
	// reaches zero from a 32-bit depth, so the small-disparity case needs no hardware.
	always_comb begin
		if (cmd.div_sel_scale) begin
			div_hi = {12'd0, scale_gain_q[31:12]};
			div_lo = {scale_gain_q[11:0], 20'd0};
			div_dvs = disp_q;
		end else begin
			div_hi = DISP_NUM_HI;
			div_lo = '0;
			div_dvs = min_q;
		end
	end

	dpds_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.num_hi   (div_hi),
		.num_lo   (div_lo),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_disp_q <= disp_q;
			out_scale_q <= div_quo;
			out_index_q <= index_q;
			out_last_q <= last_q;
		end
	end

	assign status.closes_cell = active_q && odd_col_q && odd_row_q;
	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data = {2'b00, out_index_q, out_scale_q, out_disp_q};
	assign out_last = out_last_q;

endmodule

### design/dpds_ctrl.sv
// Controller state machine sequencing capture, scaling, pooling, the two divisions and output.
module dpds_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output dpds_pkg::dp_cmd_t    cmd,
	input  dpds_pkg::dp_status_t status
);
	import dpds_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = ST_MULT;
				end
			end
			ST_MULT: begin
				cmd.mult = 1'b1;
				state_d = ST_POOL;
			end
			ST_POOL: begin
				cmd.pool = 1'b1;
				state_d = status.closes_cell ? ST_DIV_DISP : ST_IDLE;
			end
			ST_DIV_DISP: begin
				cmd.div_start = 1'b1;
				state_d = ST_WAIT_DISP;
			end
			ST_WAIT_DISP: begin
				if (status.div_done) begin
					cmd.cap_disp = 1'b1;
					state_d = ST_DIV_SCALE;
				end
			end
			ST_DIV_SCALE: begin
				cmd.div_start = 1'b1;
				cmd.div_sel_scale = 1'b1;
				state_d = ST_WAIT_SCALE;
			end
			ST_WAIT_SCALE: begin
				cmd.div_sel_scale = 1'b1;
				if (status.div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

### design/depth_pool_disparity_scale.sv
// Top level of the 2x2 inverse-depth pooling block with disparity and scale outputs.
//
// Depth samples (unsigned Q12.20) arrive one per transfer in raster order. With
// normalization on, each sample is multiplied by depth_gain (Q16.16) and clamped at
// 100.0. Pooling works by minimum depth: even rows leave one pair minimum per column
// pair in a line store of MAX_WIDTH/2 words, and each odd-row pair closes a 2x2 cell.
// A cell produces one result transfer: disparity = 2^44 / min (Q8.24, saturating, and
// all ones for a zero depth), gauss_scale = scale_gain / disparity (Q12.20,
// saturating), the cell's raster index and tlast on the final cell of the frame. An
// odd last column or row is consumed without forming a cell. An item that closes no
// cell passes through capture, gain multiply and pool; one that closes a cell then
// runs the two 32-step divisions one after the other on the single bit-serial
// divider, and a division whose quotient saturates finishes at once. A new sample is
// taken only once the last one is through. The result then waits in the output register
// while the next sample is accepted. The line store needs no clearing after reset.
// Configuration writes are always accepted and must only be made while the block is idle.
module depth_pool_disparity_scale #(
	parameter int unsigned MAX_WIDTH = 4096,
	parameter int unsigned MAX_HEIGHT = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write channel: register index and data.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dpds_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [31:0]                         cfg_data,
	// Input stream. tdata: [31:0] depth_sample.
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [31:0]                         s_axis_tdata,
	// Output stream. tdata: [31:0] disparity, [63:32] gauss_scale,
	// [85:64] cell_index, [87:86] zero. tlast: last_cell.
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [dpds_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output logic                                m_axis_tlast
);
	import dpds_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// The controller only sequences; all arithmetic and storage sit in the datapath.
	dpds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.status   (status)
	);

	dpds_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

### tb/testbench.sv
// Self-checking testbench of the 2x2 inverse-depth pooling block with disparity and scale.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dpds_pkg::*;

	// The instance keeps its default frame bounds; the predictor clamps with the same values.
	localparam int unsigned WIDTH_MAX = 4096;
	localparam int unsigned HEIGHT_MAX = 4096;
	localparam int unsigned STORE_WORDS = WIDTH_MAX / 2;
	// Normalized depth saturates at 100.0 in Q12.20.
	localparam logic [63:0] DEPTH_LIMIT = 64'd100 << 20;
	// A closing item keeps the block busy through both divisions, and this pause
	// leaves the block idle before any register is written.
	localparam int unsigned DRAIN_CYCLES = 120;
	// Cycles without any transfer that end the run; well above the long hold-off.
	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned HOLD_OFF_CYCLES = 1500;

	// One pooled cell as the output stream carries it.
	typedef struct packed {
		logic [31:0] disparity;
		logic [31:0] gauss_scale;
		logic [CELL_W-1:0] cell_index;
		logic last_cell;
	} cell_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tlast;

	// Register copies as the block holds them after reset.
	logic [12:0] frame_width_q = 13'd640;
	logic [12:0] frame_height_q = 13'd480;
	logic normalize_q = 1'b0;
	logic [31:0] depth_gain_q = 32'd65536;
	logic [31:0] scale_gain_q = 32'd16777216;

	// Pooling state of the predictor.
	int unsigned col_pos = 0;
	int unsigned row_pos = 0;
	logic [31:0] pair_min = '0;
	logic [31:0] row_pairs [STORE_WORDS];
	logic [CELL_W-1:0] cell_num = '0;

	// Cells that the predictor has computed and the output stream still owes.
	cell_result_t pending_cells[$];
	cell_result_t oldest_cell;

	int unsigned error_count = 0;
	int unsigned items_sent = 0;
	// Percent of cycles in which the sender idles and the receiver stalls.
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	// Cycles for which the receiver holds tready low regardless of stall_pct.
	int unsigned hold_off = 0;

	depth_pool_disparity_scale #(
		.MAX_WIDTH(WIDTH_MAX),
		.MAX_HEIGHT(HEIGHT_MAX)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------------

	// Frame dimensions outside [2, max] act as the nearest bound.
	function automatic int unsigned clamp_dim(input logic [12:0] value, input int unsigned hi);
		if (value < 2) begin
			return 2;
		end
		if (value > hi) begin
			return hi;
		end
		return value;
	endfunction

	function automatic logic [31:0] min32(input logic [31:0] a, input logic [31:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [31:0] saturate32(input logic [63:0] value);
		return (value > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : value[31:0];
	endfunction

	// Track one register write in the predictor's copy of the configuration.
	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] index, input logic [31:0] data);
		case (index)
			REG_FRAME_WIDTH: frame_width_q = data[12:0];
			REG_FRAME_HEIGHT: frame_height_q = data[12:0];
			REG_NORMALIZE_ENABLE: normalize_q = data[0];
			REG_DEPTH_GAIN: depth_gain_q = data;
			REG_SCALE_GAIN: scale_gain_q = data;
			default: ;
		endcase
	endfunction

	// Advance the pooling state by one accepted depth sample. A sample that closes
	// a 2x2 cell queues the cell's disparity, scale, index and last flag.
	function automatic void pool_depth_sample(input logic [31:0] depth_in);
		int unsigned w;
		int unsigned h;
		int unsigned w_even;
		int unsigned h_even;
		int unsigned slot;
		logic [63:0] scaled;
		logic [31:0] d;
		logic [31:0] cell_min;
		logic [31:0] disp;
		logic [31:0] gsc;
		cell_result_t result;
		w = clamp_dim(frame_width_q, WIDTH_MAX);
		h = clamp_dim(frame_height_q, HEIGHT_MAX);
		w_even = w & ~32'd1;
		h_even = h & ~32'd1;
		d = depth_in;
		if (normalize_q) begin
			scaled = (64'(depth_in) * 64'(depth_gain_q)) >> 16;
			if (scaled > DEPTH_LIMIT) begin
				scaled = DEPTH_LIMIT;
			end
			d = scaled[31:0];
		end
		// An odd last column or row, or a position beyond a shrunken bound, takes
		// part in no cell.
		if (col_pos < w_even && row_pos < h_even) begin
			slot = (col_pos >> 1) & (STORE_WORDS - 1);
			if ((col_pos & 1) == 0) begin
				pair_min = d;
			end else if ((row_pos & 1) == 0) begin
				row_pairs[slot] = min32(pair_min, d);
			end else begin
				cell_min = min32(min32(pair_min, d), row_pairs[slot]);
				// A zero depth and a quotient above 32 bits both saturate.
				disp = (cell_min == 0) ? 32'hFFFF_FFFF
					: saturate32((64'd1 << 44) / 64'(cell_min));
				// A zero disparity code stands for a disparity at or below 1e-8.
				gsc = (disp == 0) ? saturate32((64'(scale_gain_q) * 64'd100000000) >> 4)
					: saturate32((64'(scale_gain_q) << 20) / 64'(disp));
				result.disparity = disp;
				result.gauss_scale = gsc;
				result.cell_index = cell_num;
				result.last_cell = (col_pos == w_even - 1) && (row_pos == h_even - 1);
				pending_cells.push_back(result);
				cell_num = cell_num + 1'b1;
			end
		end
		// Counters wrap at the end of a row and of the frame.
		if (col_pos + 1 >= w) begin
			col_pos = 0;
			if (row_pos + 1 >= h) begin
				row_pos = 0;
				cell_num = '0;
			end else begin
				row_pos = row_pos + 1;
			end
		end else begin
			col_pos = col_pos + 1;
		end
	endfunction

	// ---------------------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------------------

	// Send one depth sample. The task is entered at a falling edge and leaves at
	// one with tvalid still high, so a following transfer goes out back to back;
	// quiesce lowers it.
	task automatic send_depth(input logic [31:0] depth);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tdata <= depth;
		s_axis_tvalid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		pool_depth_sample(depth);
		items_sent++;
		@(negedge clk);
	endtask

	// Stop the input stream, wait for every owed cell, then let the block settle
	// so that a register write finds it idle.
	task automatic quiesce();
		s_axis_tvalid <= 1'b0;
		while (pending_cells.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [31:0] data);
		cfg_index <= index;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		apply_reg(index, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Random bits above a 13-bit dimension, which the register drops.
	function automatic logic [31:0] with_noise(input int unsigned dim);
		return ($urandom() & 32'hFFFF_E000) | (dim & 32'h1FFF);
	endfunction

	// Mostly small frames; now and then a value below the lower bound.
	function automatic int unsigned random_dim(input int unsigned hi);
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, 1);
			1: return 2;
			default: return $urandom_range(3, hi);
		endcase
	endfunction

	function automatic logic [31:0] random_gain(input logic [31:0] unity);
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return unity;
			3: return $urandom_range(unity / 2, unity * 2);
			default: return $urandom();
		endcase
	endfunction

	// Depths that reach zero, the disparity overflow region just around 4096,
	// the normalization clamp, the top code and the full range.
	function automatic logic [31:0] random_depth();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return $urandom_range(1, 8192);
			2: return 32'hFFFF_FFFF;
			3: return $urandom_range(32'd104857600 - 4096, 32'd104857600 + 4096);
			4, 5: return $urandom();
			default: return $urandom_range(32'h0001_0000, 32'h1000_0000);
		endcase
	endfunction

	// ---------------------------------------------------------------------------
	// Receiver and checker
	// ---------------------------------------------------------------------------

	// The receiver changes tready at falling edges only. A requested hold-off is
	// counted down here, one cycle per falling edge.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				m_axis_tready <= 1'b0;
				hold_off = hold_off - 1;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	function automatic void compare_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%08h, actual 0x%08h", field, want, got);
			error_count++;
		end
	endfunction

	// Every result transfer is matched against the oldest owed cell.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			if (pending_cells.size() == 0) begin
				$error("result transfer with no cell owed: tdata 0x%022h tlast %b",
					m_axis_tdata, m_axis_tlast);
				error_count++;
			end else begin
				oldest_cell = pending_cells.pop_front();
				compare_field("disparity", oldest_cell.disparity, m_axis_tdata[31:0]);
				compare_field("gauss_scale", oldest_cell.gauss_scale, m_axis_tdata[63:32]);
				compare_field("cell_index", 32'(oldest_cell.cell_index),
					32'(m_axis_tdata[85:64]));
				compare_field("tdata padding", 32'd0, 32'(m_axis_tdata[87:86]));
				compare_field("last_cell", 32'(oldest_cell.last_cell), 32'(m_axis_tlast));
			end
		end
	end

	// Watchdog: any transfer on any channel restarts the count.
	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready === 1'b1)
					|| (m_axis_tvalid === 1'b1 && m_axis_tready)
					|| (cfg_valid && cfg_ready === 1'b1)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$error("no transfer for %0d cycles", STALL_LIMIT);
		$display("Verification failed");
		$finish;
	end

	// ---------------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------------

	// Smallest frame, two cells: a zero depth saturates disparity, and the top
	// depth code with the top scale gain saturates the scale.
	task automatic test_corner_depths();
		write_reg(REG_FRAME_WIDTH, 32'd2);
		write_reg(REG_FRAME_HEIGHT, 32'd2);
		write_reg(REG_NORMALIZE_ENABLE, 32'd0);
		write_reg(REG_DEPTH_GAIN, 32'd65536);
		write_reg(REG_SCALE_GAIN, 32'hFFFF_FFFF);
		send_depth(32'd0);
		send_depth(32'hFFFF_FFFF);
		send_depth(32'd5);
		send_depth(32'd7);
		repeat (4) send_depth(32'hFFFF_FFFF);
		quiesce();
	endtask

	// A 3x3 frame with normalization: the odd last column and row are consumed
	// without a cell, the zeros there must not reach the minimum, and a large
	// gain drives some samples into the clamp at 100.0.
	task automatic test_normalized_odd_frame();
		write_reg(REG_FRAME_WIDTH, 32'd3);
		write_reg(REG_FRAME_HEIGHT, 32'd3);
		write_reg(REG_NORMALIZE_ENABLE, 32'd1);
		write_reg(REG_DEPTH_GAIN, 32'hFFFF_FFFF);
		write_reg(REG_SCALE_GAIN, 32'd16777216);
		send_depth(32'h8000_0000);
		send_depth(32'h0000_0003);
		send_depth(32'd0);
		send_depth(32'h0012_3456);
		send_depth(32'h7FFF_FFFF);
		send_depth(32'd0);
		repeat (3) send_depth(32'd0);
		quiesce();
	endtask

	// Out-of-range dimensions clamp to the widest row and the shortest frame.
	// The row is then cut short by shrinking the width mid-frame: the next sample
	// lies beyond the new bound, is ignored and wraps into the odd row.
	task automatic test_midframe_resize();
		write_reg(REG_NORMALIZE_ENABLE, 32'd0);
		write_reg(REG_FRAME_WIDTH, 32'd8191);
		write_reg(REG_FRAME_HEIGHT, 32'd1);
		send_depth(32'd4096);
		send_depth(32'd4097);
		send_depth(32'h0100_0000);
		send_depth(32'h0200_0000);
		send_depth(32'h0300_0000);
		quiesce();
		write_reg(REG_FRAME_WIDTH, 32'd0);
		send_depth(32'd1);
		send_depth(32'h00F0_0000);
		send_depth(32'h0FF0_0000);
		quiesce();
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering
	// samples, so the output register fills and the input stalls.
	task automatic test_output_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		write_reg(REG_FRAME_WIDTH, 32'd8);
		write_reg(REG_FRAME_HEIGHT, 32'd4);
		write_reg(REG_SCALE_GAIN, 32'd16777216);
		hold_off = HOLD_OFF_CYCLES;
		repeat (32) send_depth(random_depth());
		quiesce();
	endtask

	// Random frames under random settings. Each round starts at a frame boundary,
	// where any width is safe for the line store; a round may end mid-frame with
	// a smaller width or any height, which never makes an odd row read a store
	// entry that its even row left unwritten.
	task automatic test_random_traffic(input int unsigned sender_idle,
			input int unsigned receiver_stall, input int unsigned budget);
		int unsigned first;
		int unsigned burst;
		idle_pct = sender_idle;
		stall_pct = receiver_stall;
		first = items_sent;
		while (items_sent - first < budget) begin
			while (col_pos != 0 || row_pos != 0) begin
				send_depth(random_depth());
			end
			quiesce();
			write_reg(REG_FRAME_WIDTH, with_noise(random_dim(16)));
			write_reg(REG_FRAME_HEIGHT, with_noise(random_dim(9)));
			write_reg(REG_NORMALIZE_ENABLE,
				($urandom() & 32'hFFFF_FFFE) | 32'($urandom_range(0, 1)));
			write_reg(REG_DEPTH_GAIN, random_gain(32'd65536));
			write_reg(REG_SCALE_GAIN, random_gain(32'd16777216));
			burst = $urandom_range(1, 3 * clamp_dim(frame_width_q, WIDTH_MAX)
				* clamp_dim(frame_height_q, HEIGHT_MAX));
			repeat (burst) send_depth(random_depth());
			if ($urandom_range(0, 2) == 0) begin
				quiesce();
				if ($urandom_range(0, 1) == 0) begin
					write_reg(REG_FRAME_WIDTH,
						with_noise($urandom_range(0, clamp_dim(frame_width_q, WIDTH_MAX))));
				end else begin
					write_reg(REG_FRAME_HEIGHT, with_noise($urandom_range(0, 9)));
				end
			end
		end
		quiesce();
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		idle_pct = 16;
		stall_pct = 65;
		test_corner_depths();
		test_normalized_odd_frame();
		test_midframe_resize();
		test_output_backpressure();

		test_random_traffic(16, 65, 330);
		test_random_traffic(65, 16, 330);
		test_random_traffic(0, 0, 340);

		quiesce();
		if (error_count == 0 && pending_cells.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### filelist.f
design/dpds_pkg.sv
design/dpds_div.sv
design/dpds_dp.sv
design/dpds_ctrl.sv
design/depth_pool_disparity_scale.sv
tb/testbench.sv
